/* rtl/jba_pkg.sv */
// types, constants and codes shared by the job batch aggregator
`timescale 1ns / 1ps
`default_nettype none

package jba_pkg;

   localparam int PAY_W      = 32;
   localparam int TAG_W      = 16;
   localparam int SEQ_W      = 16;
   localparam int SLOT_W     = 6;
   localparam int JOBS_W     = 7;
   localparam int BYTES_W    = 38;
   localparam int TICKS_W    = 16;
   localparam int CAUSE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 38;

   // hard cap on jobs per batch
   localparam int MAX_JOBS = 64;

   // entries in the queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;

   localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

   localparam logic [JOBS_W-1:0]  RESET_MAX_JOBS  = 7'd64;
   localparam logic [BYTES_W-1:0] RESET_MIN_BYTES = 38'd65536;
   localparam logic [TICKS_W-1:0] RESET_WINDOW    = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JOBS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW    = 2'd2;

   localparam logic FUNC_JOB  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic KIND_PLACE = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_COUNT   = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_BYTES   = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd3;

   typedef struct packed {
      logic               func;
      logic [PAY_W-1:0]   payload_bytes;
      logic [TAG_W-1:0]   job_tag;
   } jba_req_type;

   typedef struct packed {
      logic               kind;
      logic [TAG_W-1:0]   tag_out;
      logic [SEQ_W-1:0]   batch_number;
      logic [SLOT_W-1:0]  slot_in_batch;
      logic [JOBS_W-1:0]  batch_jobs;
      logic [BYTES_W-1:0] batch_bytes;
      logic [CAUSE_W-1:0] close_cause;
      logic               last;
   } jba_rsp_type;

   // one accepted item as handed from front to back
   typedef struct packed {
      logic               has_place;
      logic [TAG_W-1:0]   tag;
      logic [SEQ_W-1:0]   seq;
      logic [SLOT_W-1:0]  slot;
      logic [JOBS_W-1:0]  jobs;
      logic [BYTES_W-1:0] bytes;
      logic [CAUSE_W-1:0] cause;
   } jba_entry_type;

endpackage

`default_nettype wire

/* rtl/jba_front.sv */
// front part: accepts items, keeps batch state and configuration, classifies
`timescale 1ns / 1ps
`default_nettype none

module jba_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire jba_pkg::jba_req_type            req_data,
   input  wire logic                            csr_we,
   input  wire logic [jba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [jba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output jba_pkg::jba_entry_type               q_entry
);
   import jba_pkg::*;

   logic [JOBS_W-1:0]  max_jobs_ff;
   logic [BYTES_W-1:0] min_bytes_ff;
   logic [TICKS_W-1:0] window_ff;

   logic               open_ff,  open_in;
   logic [JOBS_W-1:0]  jobs_ff,  jobs_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;
   logic [SEQ_W-1:0]   seq_ff,   seq_in;

   logic               accept;
   logic [JOBS_W-1:0]  limit;
   logic [JOBS_W-1:0]  base_jobs;
   logic [BYTES_W-1:0] base_bytes;
   logic [TICKS_W-1:0] base_ticks;
   logic [JOBS_W-1:0]  job_jobs;
   logic [BYTES_W:0]   sum;
   logic [BYTES_W-1:0] job_bytes;
   logic [CAUSE_W-1:0] job_cause;
   logic [TICKS_W-1:0] tick_ticks;
   logic               tick_close;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   always_comb begin
      if (max_jobs_ff == '0) begin
         limit = JOBS_W'(1);
      end else if (int'(max_jobs_ff) > MAX_JOBS) begin
         limit = JOBS_W'(MAX_JOBS);
      end else begin
         limit = max_jobs_ff;
      end

      base_jobs  = open_ff ? jobs_ff  : '0;
      base_bytes = open_ff ? bytes_ff : '0;
      base_ticks = open_ff ? ticks_ff : '0;

      job_jobs  = base_jobs + JOBS_W'(1);
      sum       = {1'b0, base_bytes} + (BYTES_W+1)'(req_data.payload_bytes);
      job_bytes = sum[BYTES_W] ? BYTES_MAX : sum[BYTES_W-1:0];

      if (job_jobs >= limit) begin
         job_cause = CAUSE_COUNT;
      end else if (job_bytes >= min_bytes_ff) begin
         job_cause = CAUSE_BYTES;
      end else if (base_ticks >= window_ff) begin
         job_cause = CAUSE_TIMEOUT;
      end else begin
         job_cause = CAUSE_NONE;
      end

      tick_ticks = (ticks_ff == '1) ? ticks_ff : ticks_ff + TICKS_W'(1);
      tick_close = tick_ticks >= window_ff;
   end

   always_comb begin
      open_in  = open_ff;
      jobs_in  = jobs_ff;
      bytes_in = bytes_ff;
      ticks_in = ticks_ff;
      seq_in   = seq_ff;
      q_push   = 1'b0;
      q_entry  = '{has_place: 1'b0, tag: '0, seq: seq_ff, slot: '0,
                   jobs: jobs_ff, bytes: bytes_ff, cause: CAUSE_TIMEOUT};

      if (accept) begin
         if (req_data.func == FUNC_TICK) begin
            if (open_ff) begin
               if (tick_close) begin
                  q_push   = 1'b1;
                  open_in  = 1'b0;
                  jobs_in  = '0;
                  bytes_in = '0;
                  ticks_in = '0;
                  seq_in   = seq_ff + SEQ_W'(1);
               end else begin
                  ticks_in = tick_ticks;
               end
            end
         end else begin
            q_push  = 1'b1;
            q_entry = '{has_place: 1'b1, tag: req_data.job_tag, seq: seq_ff,
                        slot: base_jobs[SLOT_W-1:0], jobs: job_jobs,
                        bytes: job_bytes, cause: job_cause};
            if (job_cause != CAUSE_NONE) begin
               open_in  = 1'b0;
               jobs_in  = '0;
               bytes_in = '0;
               ticks_in = '0;
               seq_in   = seq_ff + SEQ_W'(1);
            end else begin
               open_in  = 1'b1;
               jobs_in  = job_jobs;
               bytes_in = job_bytes;
               ticks_in = base_ticks;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_jobs_ff  <= RESET_MAX_JOBS;
         min_bytes_ff <= RESET_MIN_BYTES;
         window_ff    <= RESET_WINDOW;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_JOBS:  max_jobs_ff  <= csr_wdata[JOBS_W-1:0];
            CSR_MIN_BYTES: min_bytes_ff <= csr_wdata[BYTES_W-1:0];
            CSR_WINDOW:    window_ff    <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         jobs_ff  <= '0;
         bytes_ff <= '0;
         ticks_ff <= '0;
         seq_ff   <= '0;
      end else begin
         open_ff  <= open_in;
         jobs_ff  <= jobs_in;
         bytes_ff <= bytes_in;
         ticks_ff <= ticks_in;
         seq_ff   <= seq_in;
      end
   end

   // a closing item leaves no batch open and advances the batch number
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.cause != CAUSE_NONE |=> !open_ff && seq_ff == $past(seq_ff) + SEQ_W'(1))
      else $error("batch still open after close");

   // an open batch always holds at least one job
   a_open_has_job: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> jobs_ff != '0)
      else $error("open batch with no jobs");

endmodule

`default_nettype wire

/* rtl/jba_queue.sv */
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module jba_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire jba_pkg::jba_entry_type  push_entry,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         head_valid,
   output jba_pkg::jba_entry_type       head_entry
);
   import jba_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   jba_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from empty queue");

   // pointers and fill count stay consistent
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff[PTR_W-1:0] == PTR_W'(wr_ptr_ff - rd_ptr_ff))
      else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

/* rtl/jba_back.sv */
// back part: turns queued items into placement and close results
`timescale 1ns / 1ps
`default_nettype none

module jba_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire jba_pkg::jba_entry_type  head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output jba_pkg::jba_rsp_type         rsp_data
);
   import jba_pkg::*;

   logic        out_valid_ff, out_valid_in;
   jba_rsp_type out_ff,       out_in;
   logic        pend_ff,      pend_in;
   jba_rsp_type pend_res_ff,  pend_res_in;

   jba_rsp_type place_res;
   jba_rsp_type close_res;
   logic        load;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign load      = !out_valid_ff || !rsp_stall;

   always_comb begin
      place_res = '{kind: KIND_PLACE, tag_out: head_entry.tag,
                    batch_number: head_entry.seq, slot_in_batch: head_entry.slot,
                    batch_jobs: head_entry.jobs, batch_bytes: head_entry.bytes,
                    close_cause: CAUSE_NONE,
                    last: head_entry.cause == CAUSE_NONE};
      close_res = '{kind: KIND_CLOSE, tag_out: '0,
                    batch_number: head_entry.seq, slot_in_batch: '0,
                    batch_jobs: head_entry.jobs, batch_bytes: head_entry.bytes,
                    close_cause: head_entry.cause, last: 1'b1};
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      pend_in      = pend_ff;
      pend_res_in  = pend_res_ff;
      pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            out_in       = pend_res_ff;
            out_valid_in = 1'b1;
            pend_in      = 1'b0;
         end else if (head_valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            if (head_entry.has_place) begin
               out_in      = place_res;
               pend_in     = head_entry.cause != CAUSE_NONE;
               pend_res_in = close_res;
            end else begin
               out_in = close_res;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      pend_res_ff <= pend_res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // a held close result always follows a placement still on the port
   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_valid_ff && out_ff.kind == KIND_PLACE && !out_ff.last)
      else $error("pending close without its placement");

   // no new item is taken while a close result is held back
   a_no_pop_pending: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !pop)
      else $error("item taken while close pending");

endmodule

`default_nettype wire

/* rtl/job_batch_aggregator.sv */
// top level of the job batch aggregator
`timescale 1ns / 1ps
`default_nettype none

// Groups jobs into batches: a job item is placed in the open batch (opening one if
// needed) and gives a placement result; it also gives a close result when the job
// count, byte total or elapsed ticks reach their limits. A tick item advances the
// open batch's elapsed count and may close it by timeout. One item is accepted per
// cycle while the four-entry queue between the classifying front and the result
// back has room; a result passes through the queue and the back's output register
// before it is offered. A job that closes its batch gives a placement result and
// then a close result, so the sustained rate is one item per cycle while the
// result port is not stalled, and lower when jobs close batches.
module job_batch_aggregator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire jba_pkg::jba_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output jba_pkg::jba_rsp_type                 rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [jba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [jba_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import jba_pkg::*;

   logic          q_push;
   logic          q_full;
   jba_entry_type q_entry;
   jba_entry_type head_entry;
   logic          head_valid;
   logic          pop;

   jba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   jba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   jba_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
